>>> sv/gbp_pkg.sv
// Package for the grid wall-follow planner: constants, payload structs, codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gbp_pkg;
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int RW = 6;
    localparam int MAP_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int MAP_AW = $clog2(MAP_DEPTH);

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_PLACE = 2'd1;
    localparam logic [1:0] KIND_REQ   = 2'd2;
    localparam logic [1:0] KIND_NOP   = 2'd3;

    localparam logic [1:0] ST_MOVED = 2'd0;
    localparam logic [1:0] ST_ACK   = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;

    localparam logic [2:0] CFG_GOAL_ROW = 3'd0;
    localparam logic [2:0] CFG_GOAL_COL = 3'd1;
    localparam logic [2:0] CFG_MAP_ROWS = 3'd2;
    localparam logic [2:0] CFG_MAP_COLS = 3'd3;
    localparam logic [2:0] CFG_WALK_LIM = 3'd4;

    typedef struct packed {
        logic [1:0] kind;
        logic [5:0] row;
        logic [5:0] col;
        logic       wall;
    } t_in;

    typedef struct packed {
        logic [5:0] pos_row;
        logic [5:0] pos_col;
        logic [1:0] status;
    } t_out;

    // squared distance between (tr,tc) and a signed candidate (r,c)
    function automatic logic [13:0] dist_sq(input logic [5:0] tr, input logic [5:0] tc,
                                            input logic signed [7:0] r,
                                            input logic signed [7:0] c);
        logic signed [17:0] a;
        logic signed [17:0] b;
        logic signed [17:0] s;
        begin
            a = $signed({12'd0, tr}) - 18'(r);
            b = $signed({12'd0, tc}) - 18'(c);
            s = a * a + b * b;
            return s[13:0];
        end
    endfunction
endpackage
`default_nettype wire

>>> sv/gbp_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gbp_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and read one word; a read during a write returns the old word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

>>> sv/grid_bug1_wall_follow_planner.sv
// Bug1 grid planner. Each transfer writes a map cell, places the robot, asks
// for a move or is a no-op; one result per item. A write or place passes
// through accept, output stage and result. A request first runs a greedy
// pass on the shared distance unit; each map sense runs issue, wait for the
// registered map RAM, capture, act. If no heading improves, the target toggles
// and the greedy pass reruns once; each silent boundary step runs four senses,
// decision, move, closest-cell check and loop head, bounded by walk_limit. After
// reset the map is cleared, one cell a cycle, during which no item is taken.
// Depends on gbp_pkg and gbp_ram.
`timescale 1ns / 1ps
`default_nettype none
module grid_bug1_wall_follow_planner (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire gbp_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_ready,
    output gbp_pkg::t_out      o_data,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data
);
    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_GREED = 13'b0000000000100, // evaluate greedy heading, one dir a cycle
        S_TOG   = 13'b0000000001000,
        S_SENSE = 13'b0000000010000, // issue map read for r_sd
        S_SWAIT = 13'b0000000100000,
        S_SGET  = 13'b0000001000000,
        S_DISP  = 13'b0000010000000, // act on sensed result
        S_WALK  = 13'b0000100000000, // walk loop head
        S_EDGE  = 13'b0001000000000, // edge-step decision
        S_BEST  = 13'b0010000000000,
        S_OUT   = 13'b0100000000000,
        S_WAIT  = 13'b1000000000000
    } t_state;

    // purpose of the running edge step
    localparam logic [1:0] EP_NONE = 2'd0;
    localparam logic [1:0] EP_WALK = 2'd1;
    localparam logic [1:0] EP_RET  = 2'd2;

    t_state r_st, n_st;
    logic [6:0] r_map_rows, r_map_cols;
    logic [15:0] r_walk_lim, r_steps;
    logic [5:0] r_rr, r_rc, r_tr, r_tc, r_hr, r_hc, r_br, r_bc;
    logic [1:0] r_side;
    logic r_follow, r_passed, r_toggle;
    logic [12:0] r_bdist;
    logic [11:0] r_clr;
    logic [1:0] r_gd;       // greedy direction counter
    logic [2:0] r_gdir;     // greedy result, 4 = none
    logic [13:0] r_gbest;
    logic r_phase;          // greedy pass: 0 = first, 1 = post-toggle/after
    logic [1:0] r_sd;       // direction being sensed
    logic [3:0] r_blk;      // sensed blocked flags (wall or off map) by direction
    logic [1:0] r_ep;       // edge-step purpose
    logic [1:0] r_ecnt;     // which of the edge senses
    logic r_inside;
    logic r_moved;
    gbp_pkg::t_out r_out;

    // clamp map size
    logic [6:0] w_rows, w_cols;
    always_comb begin
        w_rows = (r_map_rows == 7'd0) ? 7'd1 :
                 ((r_map_rows > 7'(gbp_pkg::MAX_ROWS)) ? 7'(gbp_pkg::MAX_ROWS) : r_map_rows);
        w_cols = (r_map_cols == 7'd0) ? 7'd1 :
                 ((r_map_cols > 7'(gbp_pkg::MAX_COLS)) ? 7'(gbp_pkg::MAX_COLS) : r_map_cols);
    end

    // neighbour of the robot in direction r_sd
    logic signed [7:0] w_nr, w_nc;
    logic w_off;
    always_comb begin
        w_nr = $signed({2'b00, r_rr});
        w_nc = $signed({2'b00, r_rc});
        case (r_sd)
            2'd0: w_nr = w_nr + 8'sd1;
            2'd1: w_nc = w_nc + 8'sd1;
            2'd2: w_nr = w_nr - 8'sd1;
            default: w_nc = w_nc - 8'sd1;
        endcase
        w_off = (w_nr < 0) || (w_nc < 0) || (w_nr >= $signed({1'b0, w_rows}))
             || (w_nc >= $signed({1'b0, w_cols}));
    end

    // shared distance unit
    logic signed [7:0] w_dr, w_dc;
    logic [13:0] w_dist;
    always_comb begin
        w_dr = $signed({2'b00, r_rr});
        w_dc = $signed({2'b00, r_rc});
        if (r_st == S_GREED && r_inside) begin
            case (r_gd)
                2'd0: w_dr = w_dr + 8'sd1;
                2'd1: w_dc = w_dc + 8'sd1;
                2'd2: w_dr = w_dr - 8'sd1;
                default: w_dc = w_dc - 8'sd1;
            endcase
        end
        w_dist = gbp_pkg::dist_sq(r_tr, r_tc, w_dr, w_dc);
    end

    // map RAM
    logic w_we, w_rd;
    logic [gbp_pkg::MAP_AW-1:0] w_addr;
    logic w_wdata;
    always_comb begin
        w_we = 1'b0;
        w_wdata = 1'b0;
        w_addr = {w_nr[5:0], w_nc[5:0]};
        if (r_st == S_CLEAR) begin
            w_we = 1'b1;
            w_addr = r_clr;
        end else if (r_st == S_IDLE && i_valid && i_data.kind == gbp_pkg::KIND_WRITE) begin
            w_we = 1'b1;
            w_wdata = i_data.wall;
            w_addr = {i_data.row, i_data.col};
        end
    end
    gbp_ram #(.WIDTH(1), .DEPTH(gbp_pkg::MAP_DEPTH)) u_map (
        .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr), .i_wdata(w_wdata), .o_rdata(w_rd)
    );

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_WAIT);
    assign o_data = r_out;

    // helpers for edge step
    logic [1:0] w_d, w_cw, w_op, w_ccw;
    always_comb begin
        w_d = r_side;
        w_cw = r_side + 2'd1;
        w_op = r_side + 2'd2;
        w_ccw = r_side + 2'd3;
    end

    logic [5:0] w_mr, w_mc;     // robot moved by r_sd
    always_comb begin
        w_mr = w_nr[5:0];
        w_mc = w_nc[5:0];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLEAR;
            r_clr <= '0;
            r_map_rows <= 7'd64; r_map_cols <= 7'd64;
            r_walk_lim <= 16'd16384;
            r_rr <= '0; r_rc <= '0; r_tr <= 6'd0; r_tc <= 6'd63;
            r_side <= '0; r_follow <= 1'b0; r_hr <= '0; r_hc <= '0;
            r_br <= '0; r_bc <= '0; r_bdist <= '0; r_passed <= 1'b0;
            r_toggle <= 1'b1;
            r_ep <= EP_NONE;
        end else begin
            r_st <= n_st;
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    gbp_pkg::CFG_GOAL_ROW: r_tr <= i_cfg_data[5:0];
                    gbp_pkg::CFG_GOAL_COL: r_tc <= i_cfg_data[5:0];
                    gbp_pkg::CFG_MAP_ROWS: r_map_rows <= i_cfg_data[6:0];
                    gbp_pkg::CFG_MAP_COLS: r_map_cols <= i_cfg_data[6:0];
                    gbp_pkg::CFG_WALK_LIM: r_walk_lim <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_st)
                S_CLEAR: r_clr <= r_clr + 12'd1;
                S_IDLE: if (i_valid) begin
                    r_out.status <= gbp_pkg::ST_ACK;
                    r_phase <= 1'b0;
                    if (i_data.kind == gbp_pkg::KIND_PLACE) begin
                        r_rr <= i_data.row; r_rc <= i_data.col; r_follow <= 1'b0;
                    end
                    r_gd <= 2'd0; r_gdir <= 3'd4; r_inside <= 1'b0;
                    r_ep <= EP_NONE;
                end
                S_GREED: begin
                    if (!r_inside) begin
                        r_gbest <= w_dist; r_inside <= 1'b1;
                    end else begin
                        if (w_dist < r_gbest) begin
                            r_gbest <= w_dist; r_gdir <= {1'b0, r_gd};
                        end
                        r_gd <= r_gd + 2'd1;
                    end
                end
                S_TOG: begin
                    r_tr <= 6'd0;
                    r_tc <= r_toggle ? 6'd0 : 6'(w_cols - 7'd1);
                    r_toggle <= ~r_toggle;
                    r_phase <= 1'b1;
                    r_gd <= 2'd0; r_gdir <= 3'd4; r_inside <= 1'b0;
                end
                S_SGET: r_blk[r_sd] <= w_off | w_rd;
                S_EDGE: begin
                    r_moved <= 1'b1;
                    if (r_blk[w_d] && !r_blk[w_cw]) begin
                        r_sd <= w_cw;
                    end else if (!r_blk[w_d]) begin
                        r_sd <= w_d; r_side <= w_ccw;
                    end else if (!r_blk[w_op]) begin
                        r_sd <= w_op; r_side <= w_cw;
                    end else if (!r_blk[w_ccw]) begin
                        r_sd <= w_ccw; r_side <= w_op;
                    end else begin
                        r_moved <= 1'b0;
                    end
                end
                default: ;
            endcase
            // sequencing of sense chains and moves
            case (r_st)
                S_GREED: if (r_inside && r_gd == 2'd3) begin
                    // while returning, a request that finds a better heading takes one edge step
                    if (r_follow && (w_dist < r_gbest || r_gdir != 3'd4)) begin
                        r_sd <= r_side; r_ep <= EP_RET;
                    end else begin
                        r_sd <= (w_dist < r_gbest) ? 2'd3 : r_gdir[1:0];
                        r_ep <= EP_NONE;
                    end
                    r_ecnt <= 2'd0;
                end
                S_DISP: begin
                    if (r_ep == EP_NONE) begin
                        if (!r_blk[r_sd]) begin
                            r_rr <= w_mr; r_rc <= w_mc;
                            r_out.status <= gbp_pkg::ST_MOVED;
                        end else begin
                            r_side <= r_sd;
                            r_hr <= r_rr; r_hc <= r_rc; r_br <= r_rr; r_bc <= r_rc;
                            r_bdist <= w_dist[12:0];
                            r_passed <= 1'b0; r_steps <= '0;
                        end
                    end else if (r_ecnt != 2'd3) begin
                        r_ecnt <= r_ecnt + 2'd1;
                        r_sd <= r_sd + 2'd1;
                    end
                end
                S_WALK: begin
                    if (r_rr == r_hr && r_rc == r_hc && !r_passed) r_passed <= 1'b1;
                    if (r_rr == r_hr && r_rc == r_hc && r_passed) begin
                        if (r_br == r_hr && r_bc == r_hc) begin
                            r_follow <= 1'b0; r_out.status <= gbp_pkg::ST_ACK;
                            r_ep <= EP_NONE;
                        end else begin
                            r_follow <= 1'b1; r_ep <= EP_RET;
                            r_sd <= r_side; r_ecnt <= 2'd0;
                        end
                    end else if (r_steps >= r_walk_lim) begin
                        r_rr <= r_hr; r_rc <= r_hc; r_follow <= 1'b0;
                        r_out.status <= gbp_pkg::ST_LIMIT;
                        r_ep <= EP_NONE;
                    end else begin
                        r_steps <= r_steps + 16'd1;
                        r_ep <= EP_WALK; r_sd <= r_side; r_ecnt <= 2'd0;
                    end
                end
                S_BEST: begin
                    if (r_moved) begin
                        r_rr <= w_mr; r_rc <= w_mc;
                    end
                end
                default: ;
            endcase
            // closest-cell and return bookkeeping in the cycle after the move
            if (r_st == S_OUT) begin
                if (r_ep == EP_WALK) begin
                    if (w_dist < {1'b0, r_bdist}) begin
                        r_bdist <= w_dist[12:0]; r_br <= r_rr; r_bc <= r_rc;
                    end
                end else if (r_ep == EP_RET) begin
                    if (r_rr == r_br && r_rc == r_bc) r_follow <= 1'b0;
                    r_out.status <= r_moved ? gbp_pkg::ST_MOVED : gbp_pkg::ST_ACK;
                end
                r_out.pos_row <= r_rr; r_out.pos_col <= r_rc;
            end
        end
    end

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_CLEAR: if (r_clr == 12'(gbp_pkg::MAP_DEPTH - 1)) n_st = S_IDLE;
            S_IDLE: if (i_valid) n_st = (i_data.kind == gbp_pkg::KIND_REQ) ? S_GREED : S_OUT;
            S_GREED: if (r_inside && r_gd == 2'd3) begin
                if (w_dist < r_gbest || r_gdir != 3'd4) begin
                    n_st = (r_follow) ? S_SENSE : S_SENSE;
                end else if (!r_phase) begin
                    n_st = S_TOG;
                end else begin
                    n_st = S_OUT;
                end
            end
            S_TOG: n_st = S_GREED;
            S_SENSE: n_st = S_SWAIT;
            S_SWAIT: n_st = S_SGET;
            S_SGET: n_st = S_DISP;
            S_DISP: begin
                if (r_ep == EP_NONE) n_st = r_blk[r_sd] ? S_WALK : S_OUT;
                else if (r_ecnt != 2'd3) n_st = S_SENSE;
                else n_st = S_EDGE;
            end
            S_WALK: n_st = S_SENSE;
            S_EDGE: n_st = S_BEST;
            S_BEST: n_st = (r_ep == EP_WALK) ? S_OUT : S_OUT;
            S_OUT: n_st = S_WAIT;
            S_WAIT: if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
        // walk loop: after a walk step's bookkeeping, go back to the loop head
        if (r_st == S_OUT && r_ep == EP_WALK) n_st = S_WALK;
        if (r_st == S_WALK) begin
            if (r_rr == r_hr && r_rc == r_hc && r_passed
                && r_br == r_hr && r_bc == r_hc) n_st = S_OUT;
            else if (!(r_rr == r_hr && r_rc == r_hc && r_passed)
                     && r_steps >= r_walk_lim) n_st = S_OUT;
        end
        if (r_st == S_GREED && r_inside && r_gd == 2'd3 && r_follow
            && (w_dist < r_gbest || r_gdir != 3'd4)) n_st = S_SENSE;
    end

`ifndef ASSERT_OFF
    // ready and result never overlap
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready with pending result");
    // a result follows the output stage unless a walk step loops back
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && r_ep != EP_WALK) |=> o_valid)
        else $error("no result after output stage");
    // walk step count never passes the limit
    a_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_WALK && r_ep == EP_WALK) |-> (r_steps <= r_walk_lim))
        else $error("walk count beyond limit");
`endif
endmodule
`default_nettype wire
